[rtl/pva_pkg.sv]
// ----------------------------------------------------------------------------
// pva_pkg
// shared constants, codes and the channel table entry type of the
// priority voice allocator
// ----------------------------------------------------------------------------
package pva_pkg;

    localparam int CHANNELS_DEF  = 16;
    localparam int TAG_COUNT_DEF = 256;

    localparam int ACT_W = 2;
    localparam int TAG_W = 8;
    localparam int PRI_W = 8;
    localparam int VOL_W = 7;
    localparam int IDX_W = 4;
    localparam int STS_W = 4;

    // request kinds
    localparam logic [ACT_W-1:0] ACT_PLAY   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_STOP   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FINISH = 2'd2;
    localparam logic [ACT_W-1:0] ACT_FRAME  = 2'd3;

    // result status codes
    localparam logic [STS_W-1:0] ST_FREE     = 4'd0;
    localparam logic [STS_W-1:0] ST_STOLE    = 4'd1;
    localparam logic [STS_W-1:0] ST_REPLACED = 4'd2;
    localparam logic [STS_W-1:0] ST_DROPPED  = 4'd3;
    localparam logic [STS_W-1:0] ST_DUP      = 4'd4;
    localparam logic [STS_W-1:0] ST_STOPPED  = 4'd5;
    localparam logic [STS_W-1:0] ST_STOPMISS = 4'd6;
    localparam logic [STS_W-1:0] ST_FINISHED = 4'd7;
    localparam logic [STS_W-1:0] ST_FRAME    = 4'd8;

    // one channel table entry
    typedef struct packed {
        logic             playing;
        logic             tag_valid;
        logic [TAG_W-1:0] tag;
        logic [PRI_W-1:0] prio;
        logic             looping;
    } t_chan_ent;

endpackage

[rtl/priority_voice_allocator.sv]
// ----------------------------------------------------------------------------
// priority_voice_allocator
// channel table and per-frame sound table held in synchronous memories;
// a sequencer scans the channel table one entry per cycle for each play or stop request
// ----------------------------------------------------------------------------
// steps: play or stop folds the tag into range, checks the per-frame table and,
//   unless a duplicate, scans the channel table one entry read a cycle; finished
//   reads and rewrites the named entry; frame end sweeps the per-frame table
// throughput: one request at a time, the next taken the cycle after its result
//   reaches the output register, which stalls while a result there is not taken
// reset: a clearing pass over both tables, no request taken until done
module priority_voice_allocator #(
    parameter int CHANNELS  = pva_pkg::CHANNELS_DEF,
    parameter int TAG_COUNT = pva_pkg::TAG_COUNT_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [pva_pkg::ACT_W-1:0]  i_action,
    input  logic [pva_pkg::TAG_W-1:0]  i_sound_tag,
    input  logic [pva_pkg::PRI_W-1:0]  i_priority_req,
    input  logic [pva_pkg::VOL_W-1:0]  i_volume,
    input  logic                       i_loop,
    input  logic [pva_pkg::IDX_W-1:0]  i_channel_index,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [pva_pkg::STS_W-1:0]  o_status,
    output logic [pva_pkg::IDX_W-1:0]  o_channel,
    output logic [pva_pkg::TAG_W-1:0]  o_out_tag,
    output logic [pva_pkg::VOL_W-1:0]  o_out_volume,
    output logic                       o_out_loop
);

    localparam int CW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNW  = $clog2(CHANNELS + 1);
    localparam int SW   = $clog2(TAG_COUNT);
    localparam int SLW  = (SW > pva_pkg::TAG_W) ? SW : pva_pkg::TAG_W;
    localparam int MAXD = (TAG_COUNT > CHANNELS) ? TAG_COUNT : CHANNELS;
    localparam int NW   = $clog2(MAXD);

    typedef enum logic [9:0] {
        S_INIT   = 10'b00_0000_0001,
        S_IDLE   = 10'b00_0000_0010,
        S_CLEAR  = 10'b00_0000_0100,
        S_MOD    = 10'b00_0000_1000,
        S_SEEN   = 10'b00_0001_0000,
        S_SCAN   = 10'b00_0010_0000,
        S_DECIDE = 10'b00_0100_0000,
        S_FINRD  = 10'b00_1000_0000,
        S_FINWR  = 10'b01_0000_0000,
        S_RESULT = 10'b10_0000_0000
    } t_state;

    // memories
    pva_pkg::t_chan_ent chan_mem [CHANNELS];
    logic               seen_mem [TAG_COUNT];

    logic               chan_rd_en;
    logic [CW-1:0]      chan_rd_addr;
    logic               chan_wr_en;
    logic [CW-1:0]      chan_wr_addr;
    pva_pkg::t_chan_ent chan_wr_data;
    logic               seen_rd_en;
    logic [SW-1:0]      seen_rd_addr;
    logic               seen_wr_en;
    logic [SW-1:0]      seen_wr_addr;
    logic               seen_wr_data;

    pva_pkg::t_chan_ent r_chan_q;
    logic               r_seen_q;

    // control
    t_state           r_state, n_state;
    logic [NW-1:0]    r_cnt, n_cnt;
    logic [CNW-1:0]   r_scan_cnt, n_scan_cnt;
    logic             r_pend, n_pend;
    logic             r_out_valid, n_out_valid;

    // request and work registers
    logic [pva_pkg::ACT_W-1:0] r_action, n_action;
    logic [pva_pkg::TAG_W-1:0] r_tag, n_tag;
    logic [pva_pkg::PRI_W-1:0] r_prio, n_prio;
    logic [pva_pkg::VOL_W-1:0] r_vol, n_vol;
    logic                      r_loop, n_loop;
    logic [pva_pkg::IDX_W-1:0] r_idx, n_idx;
    logic [SLW-1:0]            r_slot, n_slot;
    logic                      r_fin_ok, n_fin_ok;
    logic [CW-1:0]             r_pend_idx, n_pend_idx;
    logic                      r_free_hit, n_free_hit;
    logic [CW-1:0]             r_free_idx, n_free_idx;
    logic                      r_low_hit, n_low_hit;
    logic [CW-1:0]             r_low_idx, n_low_idx;
    logic                      r_same_hit, n_same_hit;
    logic [CW-1:0]             r_same_idx, n_same_idx;
    pva_pkg::t_chan_ent        r_same_ent, n_same_ent;

    // pending result
    logic [pva_pkg::STS_W-1:0] r_res_status, n_res_status;
    logic [pva_pkg::IDX_W-1:0] r_res_chan, n_res_chan;
    logic [pva_pkg::TAG_W-1:0] r_res_tag, n_res_tag;
    logic [pva_pkg::VOL_W-1:0] r_res_vol, n_res_vol;
    logic                      r_res_loop, n_res_loop;

    // output register
    logic [pva_pkg::STS_W-1:0] r_out_status, n_out_status;
    logic [pva_pkg::IDX_W-1:0] r_out_chan, n_out_chan;
    logic [pva_pkg::TAG_W-1:0] r_out_tag, n_out_tag;
    logic [pva_pkg::VOL_W-1:0] r_out_vol, n_out_vol;
    logic                      r_out_loop, n_out_loop;

    logic in_acc;
    logic ent_free, ent_low, ent_same;

    assign o_in_ready   = (r_state == S_IDLE);
    assign in_acc       = i_in_valid && o_in_ready;
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_channel    = r_out_chan;
    assign o_out_tag    = r_out_tag;
    assign o_out_volume = r_out_vol;
    assign o_out_loop   = r_out_loop;

    // per-entry tests on the entry read back during the scan
    assign ent_free = !r_chan_q.playing;
    assign ent_low  = r_chan_q.prio < r_prio;
    assign ent_same = r_chan_q.tag_valid && (r_chan_q.tag == r_tag)
                      && ((r_action == pva_pkg::ACT_STOP) || !r_chan_q.looping);

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_scan_cnt   = r_scan_cnt;
        n_pend       = 1'b0;
        n_out_valid  = r_out_valid;
        n_action     = r_action;
        n_tag        = r_tag;
        n_prio       = r_prio;
        n_vol        = r_vol;
        n_loop       = r_loop;
        n_idx        = r_idx;
        n_slot       = r_slot;
        n_fin_ok     = r_fin_ok;
        n_pend_idx   = r_pend_idx;
        n_free_hit   = r_free_hit;
        n_free_idx   = r_free_idx;
        n_low_hit    = r_low_hit;
        n_low_idx    = r_low_idx;
        n_same_hit   = r_same_hit;
        n_same_idx   = r_same_idx;
        n_same_ent   = r_same_ent;
        n_res_status = r_res_status;
        n_res_chan   = r_res_chan;
        n_res_tag    = r_res_tag;
        n_res_vol    = r_res_vol;
        n_res_loop   = r_res_loop;
        n_out_status = r_out_status;
        n_out_chan   = r_out_chan;
        n_out_tag    = r_out_tag;
        n_out_vol    = r_out_vol;
        n_out_loop   = r_out_loop;

        chan_rd_en   = 1'b0;
        chan_rd_addr = '0;
        chan_wr_en   = 1'b0;
        chan_wr_addr = '0;
        chan_wr_data = '0;
        seen_rd_en   = 1'b0;
        seen_rd_addr = '0;
        seen_wr_en   = 1'b0;
        seen_wr_addr = '0;
        seen_wr_data = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_INIT: begin
                seen_wr_en   = 1'b1;
                seen_wr_addr = r_cnt[SW-1:0];
                if (32'(r_cnt) < CHANNELS) begin
                    chan_wr_en   = 1'b1;
                    chan_wr_addr = CW'(r_cnt);
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == NW'(MAXD - 1)) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_action = i_action;
                    n_tag    = i_sound_tag;
                    n_prio   = i_priority_req;
                    n_vol    = i_volume;
                    n_loop   = i_loop;
                    n_idx    = i_channel_index;
                    n_slot   = SLW'(i_sound_tag);
                    n_cnt    = '0;
                    unique case (i_action)
                        pva_pkg::ACT_FRAME:  n_state = S_CLEAR;
                        pva_pkg::ACT_FINISH: n_state = S_FINRD;
                        pva_pkg::ACT_PLAY,
                        pva_pkg::ACT_STOP:   n_state = S_MOD;
                        default:             n_state = S_MOD;
                    endcase
                end
            end
            S_CLEAR: begin
                seen_wr_en   = 1'b1;
                seen_wr_addr = r_cnt[SW-1:0];
                n_cnt        = r_cnt + 1'b1;
                if (r_cnt == NW'(TAG_COUNT - 1)) begin
                    n_cnt        = '0;
                    n_res_status = pva_pkg::ST_FRAME;
                    n_res_chan   = '0;
                    n_res_tag    = '0;
                    n_res_vol    = '0;
                    n_res_loop   = 1'b0;
                    n_state      = S_RESULT;
                end
            end
            S_MOD: begin
                // fold the tag into the table range by repeated subtraction
                if (32'(r_slot) >= TAG_COUNT) begin
                    n_slot = r_slot - SLW'(TAG_COUNT);
                end else begin
                    seen_rd_en   = 1'b1;
                    seen_rd_addr = r_slot[SW-1:0];
                    n_state      = S_SEEN;
                end
            end
            S_SEEN: begin
                if (r_seen_q) begin
                    n_res_status = pva_pkg::ST_DUP;
                    n_res_chan   = '0;
                    n_res_tag    = r_tag;
                    n_res_vol    = '0;
                    n_res_loop   = 1'b0;
                    n_state      = S_RESULT;
                end else begin
                    seen_wr_en   = 1'b1;
                    seen_wr_addr = r_slot[SW-1:0];
                    seen_wr_data = 1'b1;
                    n_scan_cnt   = '0;
                    n_free_hit   = 1'b0;
                    n_low_hit    = 1'b0;
                    n_same_hit   = 1'b0;
                    n_state      = S_SCAN;
                end
            end
            S_SCAN: begin
                // reads run one ahead of the evaluation of their data
                if (32'(r_scan_cnt) < CHANNELS) begin
                    chan_rd_en   = 1'b1;
                    chan_rd_addr = CW'(r_scan_cnt);
                    n_scan_cnt   = r_scan_cnt + 1'b1;
                    n_pend       = 1'b1;
                    n_pend_idx   = CW'(r_scan_cnt);
                end
                if (r_pend) begin
                    if (ent_free && !r_free_hit) begin
                        n_free_hit = 1'b1;
                        n_free_idx = r_pend_idx;
                    end
                    if (ent_low && !r_low_hit) begin
                        n_low_hit = 1'b1;
                        n_low_idx = r_pend_idx;
                    end
                    if (ent_same && !r_same_hit) begin
                        n_same_hit = 1'b1;
                        n_same_idx = r_pend_idx;
                        n_same_ent = r_chan_q;
                    end
                    if (r_pend_idx == CW'(CHANNELS - 1)) begin
                        n_state = S_DECIDE;
                    end
                end
            end
            S_DECIDE: begin
                n_res_tag  = r_tag;
                n_res_vol  = '0;
                n_res_loop = 1'b0;
                n_res_chan = '0;
                n_state    = S_RESULT;
                if (r_action == pva_pkg::ACT_STOP) begin
                    if (r_same_hit) begin
                        chan_wr_en           = 1'b1;
                        chan_wr_addr         = r_same_idx;
                        chan_wr_data         = r_same_ent;
                        chan_wr_data.playing = 1'b0;
                        n_res_status         = pva_pkg::ST_STOPPED;
                        n_res_chan           = pva_pkg::IDX_W'(r_same_idx);
                    end else begin
                        n_res_status = pva_pkg::ST_STOPMISS;
                    end
                end else begin
                    chan_wr_data.playing   = 1'b1;
                    chan_wr_data.tag_valid = 1'b1;
                    chan_wr_data.tag       = r_tag;
                    chan_wr_data.prio      = r_prio;
                    chan_wr_data.looping   = r_loop;
                    priority if (r_free_hit) begin
                        chan_wr_en   = 1'b1;
                        chan_wr_addr = r_free_idx;
                        n_res_status = pva_pkg::ST_FREE;
                    end else if (r_low_hit) begin
                        chan_wr_en   = 1'b1;
                        chan_wr_addr = r_low_idx;
                        n_res_status = pva_pkg::ST_STOLE;
                    end else if (r_same_hit) begin
                        chan_wr_en   = 1'b1;
                        chan_wr_addr = r_same_idx;
                        n_res_status = pva_pkg::ST_REPLACED;
                    end else begin
                        n_res_status = pva_pkg::ST_DROPPED;
                    end
                    if (chan_wr_en) begin
                        n_res_chan = pva_pkg::IDX_W'(chan_wr_addr);
                        n_res_vol  = r_vol;
                        n_res_loop = r_loop;
                    end
                end
            end
            S_FINRD: begin
                n_fin_ok = (32'(r_idx) < CHANNELS);
                if (32'(r_idx) < CHANNELS) begin
                    chan_rd_en   = 1'b1;
                    chan_rd_addr = CW'(r_idx);
                end
                n_state = S_FINWR;
            end
            S_FINWR: begin
                // the named channel stops but keeps its recorded sound
                if (r_fin_ok) begin
                    chan_wr_en           = 1'b1;
                    chan_wr_addr         = CW'(r_idx);
                    chan_wr_data         = r_chan_q;
                    chan_wr_data.playing = 1'b0;
                end
                n_res_status = pva_pkg::ST_FINISHED;
                n_res_chan   = r_idx;
                n_res_tag    = '0;
                n_res_vol    = '0;
                n_res_loop   = 1'b0;
                n_state      = S_RESULT;
            end
            S_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_chan   = r_res_chan;
                    n_out_tag    = r_res_tag;
                    n_out_vol    = r_res_vol;
                    n_out_loop   = r_res_loop;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
                n_cnt   = '0;
            end
        endcase
    end

    // channel table memory
    always_ff @(posedge i_clk) begin
        if (chan_wr_en) begin
            chan_mem[chan_wr_addr] <= chan_wr_data;
        end
        if (chan_rd_en) begin
            r_chan_q <= chan_mem[chan_rd_addr];
        end
    end

    // per-frame sound table memory
    always_ff @(posedge i_clk) begin
        if (seen_wr_en) begin
            seen_mem[seen_wr_addr] <= seen_wr_data;
        end
        if (seen_rd_en) begin
            r_seen_q <= seen_mem[seen_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cnt       <= '0;
            r_scan_cnt  <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_scan_cnt  <= n_scan_cnt;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action     <= n_action;
        r_tag        <= n_tag;
        r_prio       <= n_prio;
        r_vol        <= n_vol;
        r_loop       <= n_loop;
        r_idx        <= n_idx;
        r_slot       <= n_slot;
        r_fin_ok     <= n_fin_ok;
        r_pend_idx   <= n_pend_idx;
        r_free_hit   <= n_free_hit;
        r_free_idx   <= n_free_idx;
        r_low_hit    <= n_low_hit;
        r_low_idx    <= n_low_idx;
        r_same_hit   <= n_same_hit;
        r_same_idx   <= n_same_idx;
        r_same_ent   <= n_same_ent;
        r_res_status <= n_res_status;
        r_res_chan   <= n_res_chan;
        r_res_tag    <= n_res_tag;
        r_res_vol    <= n_res_vol;
        r_res_loop   <= n_res_loop;
        r_out_status <= n_out_status;
        r_out_chan   <= n_out_chan;
        r_out_tag    <= n_out_tag;
        r_out_vol    <= n_out_vol;
        r_out_loop   <= n_out_loop;
    end

endmodule
